### src/olist_pkg.sv
package olist_pkg;

   // field widths fixed by the transaction format
   localparam int VAL_W     = 32;
   localparam int POS_W     = 10;
   localparam int COUNT_W   = 7;
   // widest entry count / index carried between top and cells (capacity up to 1024)
   localparam int CNT_MAX_W = 11;

   localparam int DEFAULT_CAPACITY = 64;

   typedef enum logic [1:0] {
      MODE_APPEND = 2'd0,
      MODE_INSERT = 2'd1,
      MODE_DELETE = 2'd2,
      MODE_READ   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_RANGE     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SEQ_IDLE  = 2'd0,
      SEQ_SCAN  = 2'd1,
      SEQ_APPLY = 2'd2
   } seq_state_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_SCAN   = 2'd1,
      CELL_INSERT = 2'd2,
      CELL_DELETE = 2'd3
   } cell_cmd_type;

   typedef struct packed {
      mode_type                 mode;
      logic signed [VAL_W-1:0]  value;
      logic [POS_W-1:0]         position;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic [COUNT_W-1:0]       count;
      logic signed [VAL_W-1:0]  read_value;
   } rsp_type;

   // broadcast control from the sequencer to every cell
   typedef struct packed {
      cell_cmd_type             cmd;
      logic [VAL_W-1:0]         value;
      logic [POS_W-1:0]         position;
      logic [CNT_MAX_W-1:0]     ins_idx;
      logic [CNT_MAX_W-1:0]     count;
   } cell_ctl_type;

endpackage

### src/olist_cell.sv
module olist_cell #(
   parameter int INDEX = 0
) (
   input  logic                           clock,
   input  olist_pkg::cell_ctl_type        ctl,
   input  logic                           del_shift,
   input  logic [olist_pkg::VAL_W-1:0]    left_data,
   input  logic [olist_pkg::VAL_W-1:0]    right_data,
   output logic [olist_pkg::VAL_W-1:0]    data,
   output logic                           match,
   output logic [olist_pkg::VAL_W-1:0]    rd_data
);

   localparam logic [olist_pkg::CNT_MAX_W-1:0] MY_IDX = olist_pkg::CNT_MAX_W'(INDEX);

   logic [olist_pkg::VAL_W-1:0] data_ff, data_in;
   logic                        match_ff;
   logic [olist_pkg::VAL_W-1:0] rd_ff;
   logic                        live;
   logic                        pos_hit;

   assign live    = MY_IDX < ctl.count;
   assign pos_hit = olist_pkg::CNT_MAX_W'(ctl.position) == MY_IDX;

   // entry update: insert shifts toward the tail, delete pulls from the tail side
   always_comb begin
      data_in = data_ff;
      unique case (ctl.cmd)
         olist_pkg::CELL_INSERT: begin
            if (MY_IDX == ctl.ins_idx) begin
               data_in = ctl.value;
            end else if (MY_IDX > ctl.ins_idx) begin
               data_in = left_data;
            end
         end
         olist_pkg::CELL_DELETE: begin
            if (del_shift) begin
               data_in = right_data;
            end
         end
         olist_pkg::CELL_HOLD,
         olist_pkg::CELL_SCAN: begin
            data_in = data_ff;
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // per-cell compare and read select, registered during the scan cycle
   always_ff @(posedge clock) begin
      if (ctl.cmd == olist_pkg::CELL_SCAN) begin
         match_ff <= live && (data_ff == ctl.value);
         rd_ff    <= (live && pos_hit) ? data_ff : '0;
      end
   end

   assign data    = data_ff;
   assign match   = match_ff;
   assign rd_data = rd_ff;

endmodule

### src/ordered_list_engine.sv
// ordered list engine: each entry lives in its own cell of a shifting chain
// the result strobe is registered from the apply state, which follows the scan state
// a new transaction is taken only when idle; busy covers the scan and apply cycles
// the receiver cannot stall; each result is shown for exactly one cycle
// reset clears the entry count and the sequencer; entry storage is not cleared
module ordered_list_engine #(
   parameter int CAPACITY = olist_pkg::DEFAULT_CAPACITY
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  olist_pkg::req_type   req_data,
   output logic                 rsp_valid,
   output olist_pkg::rsp_type   rsp_data
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int MW = olist_pkg::CNT_MAX_W;
   localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

   olist_pkg::seq_state_type state_ff, state_in;
   olist_pkg::req_type       op_ff, op_in;
   logic [CW-1:0]            count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   olist_pkg::rsp_type       rsp_ff, rsp_in;

   olist_pkg::cell_ctl_type  ctl;
   logic [olist_pkg::VAL_W-1:0] cell_data [CAPACITY];
   logic [olist_pkg::VAL_W-1:0] cell_rd   [CAPACITY];
   logic [CAPACITY-1:0]      match_vec;
   logic [CAPACITY-1:0]      del_mask;
   logic                     found;
   logic                     full;
   logic [olist_pkg::VAL_W-1:0] rd_or;
   logic [MW-1:0]            count_ext;
   logic [MW-1:0]            pos_ext;
   logic [MW-1:0]            ins_raw;
   logic [MW-1:0]            ins_idx;
   logic                     accept;

   assign accept    = start && (state_ff == olist_pkg::SEQ_IDLE);
   assign count_ext = MW'(count_ff);
   assign pos_ext   = MW'(op_ff.position);
   assign full      = count_ff == FULL_COUNT;
   assign found     = |match_vec;

   // first matching cell and everything behind it shift toward the front
   assign del_mask = match_vec | (~match_vec + CAPACITY'(1));

   // insert point: positions 0 and 1 mean the front, past the end means the tail; append always takes the tail
   always_comb begin
      ins_raw = (pos_ext <= MW'(1)) ? '0 : pos_ext - MW'(1);
      if (op_ff.mode == olist_pkg::MODE_APPEND) begin
         ins_idx = count_ext;
      end else if (ins_raw > count_ext) begin
         ins_idx = count_ext;
      end else begin
         ins_idx = ins_raw;
      end
   end

   // read data: only the addressed live cell passes a nonzero word
   always_comb begin
      rd_or = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         rd_or = rd_or | cell_rd[k];
      end
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         olist_pkg::SEQ_IDLE:  if (start) state_in = olist_pkg::SEQ_SCAN;
         olist_pkg::SEQ_SCAN:  state_in = olist_pkg::SEQ_APPLY;
         olist_pkg::SEQ_APPLY: state_in = olist_pkg::SEQ_IDLE;
         default:              state_in = olist_pkg::SEQ_IDLE;
      endcase
   end

   // sequencer outputs: cell commands, count update and result
   always_comb begin
      ctl.cmd      = olist_pkg::CELL_HOLD;
      ctl.value    = op_ff.value;
      ctl.position = op_ff.position;
      ctl.ins_idx  = ins_idx;
      ctl.count    = count_ext;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      op_in        = accept ? req_data : op_ff;
      unique case (state_ff)
         olist_pkg::SEQ_SCAN: begin
            ctl.cmd = olist_pkg::CELL_SCAN;
         end
         olist_pkg::SEQ_APPLY: begin
            rsp_valid_in       = 1'b1;
            rsp_in.read_value  = '0;
            rsp_in.status      = olist_pkg::ST_OK;
            unique case (op_ff.mode)
               olist_pkg::MODE_APPEND,
               olist_pkg::MODE_INSERT: begin
                  if (full) begin
                     rsp_in.status = olist_pkg::ST_FULL;
                  end else begin
                     ctl.cmd  = olist_pkg::CELL_INSERT;
                     count_in = count_ff + CW'(1);
                  end
               end
               olist_pkg::MODE_DELETE: begin
                  if (found) begin
                     ctl.cmd  = olist_pkg::CELL_DELETE;
                     count_in = count_ff - CW'(1);
                  end else begin
                     rsp_in.status = olist_pkg::ST_NOT_FOUND;
                  end
               end
               olist_pkg::MODE_READ: begin
                  if (pos_ext < count_ext) begin
                     rsp_in.read_value = rd_or;
                  end else begin
                     rsp_in.status = olist_pkg::ST_RANGE;
                  end
               end
               default: begin
                  rsp_in.status = olist_pkg::ST_OK;
               end
            endcase
            rsp_in.count = olist_pkg::COUNT_W'(count_in);
         end
         olist_pkg::SEQ_IDLE: begin
            ctl.cmd = olist_pkg::CELL_HOLD;
         end
         default: begin
            ctl.cmd = olist_pkg::CELL_HOLD;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= olist_pkg::SEQ_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      rsp_ff <= rsp_in;
   end

   // chain of cells, front at index 0
   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      logic [olist_pkg::VAL_W-1:0] left_w;
      logic [olist_pkg::VAL_W-1:0] right_w;
      if (k == 0) begin : g_front
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = cell_data[k-1];
      end
      if (k == CAPACITY - 1) begin : g_tail
         assign right_w = '0;
      end else begin : g_mid_r
         assign right_w = cell_data[k+1];
      end
      olist_cell #(
         .INDEX (k)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .del_shift  (del_mask[k]),
         .left_data  (left_w),
         .right_data (right_w),
         .data       (cell_data[k]),
         .match      (match_vec[k]),
         .rd_data    (cell_rd[k])
      );
   end

   assign busy      = state_ff != olist_pkg::SEQ_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### dv/ordered_list_engine_tb.sv
`timescale 1ns / 100ps

module ordered_list_engine_tb;
   import olist_pkg::*;

   localparam int CAPACITY   = DEFAULT_CAPACITY;
   localparam int RANDOM_OPS = 1900;
   localparam int IDLE_LIMIT = 500;

   // shadow copy of the list and the results it implies
   class list_tracker;
      logic signed [VAL_W-1:0] slots [CAPACITY];
      int unsigned             fill;
      int unsigned             peak_fill;
      rsp_type                 pending_results [$];
      int unsigned             errors;
      int unsigned             ops_seen;
      int unsigned             results_checked;
      int unsigned             status_seen [4];

      function void place(int unsigned idx, logic signed [VAL_W-1:0] v);
         for (int unsigned k = fill; k > idx; k--)
            slots[k] = slots[k-1];
         slots[idx] = v;
         fill++;
         if (fill > peak_fill)
            peak_fill = fill;
      endfunction

      // work out the result of one accepted transaction
      function void note_request(req_type op);
         rsp_type     exp_rsp;
         int unsigned idx;
         exp_rsp.status     = ST_OK;
         exp_rsp.read_value = '0;
         case (op.mode)
            MODE_APPEND: begin
               if (fill >= CAPACITY)
                  exp_rsp.status = ST_FULL;
               else
                  place(fill, op.value);
            end
            MODE_INSERT: begin
               if (fill >= CAPACITY) begin
                  exp_rsp.status = ST_FULL;
               end else begin
                  idx = (op.position <= 1) ? 0 : op.position - 1;
                  if (idx > fill)
                     idx = fill;
                  place(idx, op.value);
               end
            end
            MODE_DELETE: begin
               exp_rsp.status = ST_NOT_FOUND;
               for (int unsigned k = 0; k < fill; k++) begin
                  if (slots[k] == op.value) begin
                     for (int unsigned j = k; j + 1 < fill; j++)
                        slots[j] = slots[j+1];
                     fill--;
                     exp_rsp.status = ST_OK;
                     break;
                  end
               end
            end
            default: begin
               if (op.position < fill)
                  exp_rsp.read_value = slots[op.position];
               else
                  exp_rsp.status = ST_RANGE;
            end
         endcase
         exp_rsp.count = fill[COUNT_W-1:0];
         status_seen[exp_rsp.status]++;
         ops_seen++;
         pending_results.push_back(exp_rsp);
      endfunction

      // compare one result against the oldest expectation
      function void check_result(rsp_type got);
         rsp_type exp_rsp;
         if (pending_results.size() == 0) begin
            $display("%0t: result with nothing expected, got status %0d count %0d data %h",
                     $time, got.status, got.count, got.read_value);
            errors++;
            return;
         end
         exp_rsp = pending_results.pop_front();
         results_checked++;
         if (got.status !== exp_rsp.status) begin
            $display("%0t: status mismatch, expected %0d got %0d",
                     $time, exp_rsp.status, got.status);
            errors++;
         end
         if (got.count !== exp_rsp.count) begin
            $display("%0t: count mismatch, expected %0d got %0d",
                     $time, exp_rsp.count, got.count);
            errors++;
         end
         if (got.read_value !== exp_rsp.read_value) begin
            $display("%0t: read_value mismatch, expected %h got %h",
                     $time, exp_rsp.read_value, got.read_value);
            errors++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   list_tracker tracker;
   int unsigned idle_cycles;

   ordered_list_engine #(.CAPACITY(CAPACITY)) uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // monitor both channels and watch for a stalled run
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (start && !busy)
            tracker.note_request(req_data);
         if (rsp_valid)
            tracker.check_result(rsp_data);
         if ((start && !busy) || rsp_valid)
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, tracker.pending_results.size());
            $display("** ordered_list_engine: FAILED **");
            $finish;
         end
      end
   end

   function automatic req_type op_of(mode_type m, logic [VAL_W-1:0] v, int unsigned p);
      req_type op;
      op.mode     = m;
      op.value    = v;
      op.position = p[POS_W-1:0];
      return op;
   endfunction

   // random operation, biased toward growing or shrinking the list
   function automatic req_type make_op(bit grow);
      req_type     op;
      int unsigned roll;
      int unsigned fill;
      fill = tracker.fill;
      roll = $urandom_range(0, 99);
      if (grow)
         op.mode = (roll < 35) ? MODE_APPEND : (roll < 70) ? MODE_INSERT :
                   (roll < 85) ? MODE_DELETE : MODE_READ;
      else
         op.mode = (roll < 10) ? MODE_APPEND : (roll < 20) ? MODE_INSERT :
                   (roll < 70) ? MODE_DELETE : MODE_READ;
      roll = $urandom_range(0, 99);
      if (op.mode == MODE_DELETE && fill > 0 && roll < 60)
         op.value = tracker.slots[$urandom_range(0, fill - 1)];
      else if (roll < 65)
         op.value = $signed($urandom_range(0, 16)) - 8;
      else if (roll < 85)
         op.value = $urandom;
      else
         case ($urandom_range(0, 3))
            0:       op.value = 32'h8000_0000;
            1:       op.value = 32'h7fff_ffff;
            2:       op.value = '1;
            default: op.value = '0;
         endcase
      roll = $urandom_range(0, 99);
      if (roll < 70)
         op.position = POS_W'($urandom_range(0, fill + 2));
      else if (roll < 90)
         op.position = POS_W'($urandom_range(0, 1023));
      else
         case ($urandom_range(0, 4))
            0:       op.position = POS_W'(0);
            1:       op.position = POS_W'(1);
            2:       op.position = POS_W'(1023);
            3:       op.position = POS_W'(fill);
            default: op.position = POS_W'(fill + 1);
         endcase
      return op;
   endfunction

   // present one transaction and hold it until the block takes it
   task automatic send_op(input req_type op);
      @(negedge clock);
      start    = 1'b1;
      req_data = op;
      @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   // sender gap with junk on the request bus
   task automatic hold_off(input int unsigned cycles);
      logic [63:0] junk;
      repeat (cycles) begin
         @(negedge clock);
         junk     = {$urandom, $urandom};
         start    = 1'b0;
         req_data = junk[$bits(req_type)-1:0];
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      start = 1'b0;
      while (tracker.pending_results.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      int unsigned sent;
      int unsigned burst;
      int unsigned phase_left;
      int unsigned drains;
      bit          grow;

      tracker  = new();
      start    = 1'b0;
      req_data = '0;
      reset    = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty list, ends of the position range, extreme values, duplicates
      send_op(op_of(MODE_READ,   32'd0,         0));
      send_op(op_of(MODE_READ,   32'd0,         1023));
      send_op(op_of(MODE_DELETE, 32'd5,         0));
      send_op(op_of(MODE_INSERT, 32'd7,         0));
      send_op(op_of(MODE_INSERT, 32'h7fff_ffff, 1023));
      send_op(op_of(MODE_INSERT, 32'h8000_0000, 1));
      send_op(op_of(MODE_APPEND, 32'hffff_ffff, 0));
      send_op(op_of(MODE_APPEND, 32'd0,         0));
      send_op(op_of(MODE_INSERT, 32'h5555_5555, 2));
      send_op(op_of(MODE_INSERT, 32'haaaa_aaaa, 5));
      send_op(op_of(MODE_APPEND, 32'd7,         512));
      send_op(op_of(MODE_READ,   32'd0,         0));
      send_op(op_of(MODE_READ,   32'd0,         7));
      send_op(op_of(MODE_READ,   32'd0,         8));
      send_op(op_of(MODE_DELETE, 32'd7,         0));
      send_op(op_of(MODE_DELETE, 32'd12345,     0));
      send_op(op_of(MODE_DELETE, 32'h8000_0000, 0));
      send_op(op_of(MODE_READ,   32'd0,         6));
      send_op(op_of(MODE_READ,   32'd0,         512));
      send_op(op_of(MODE_READ,   32'd0,         1));
      wait_drained();

      // random: grow and shrink phases sent in bursts with random gaps
      sent       = 0;
      drains     = 0;
      grow       = 1'b1;
      phase_left = 150;
      while (sent < RANDOM_OPS) begin
         burst = $urandom_range(1, 24);
         for (int unsigned i = 0; i < burst; i++) begin
            send_op(make_op(grow));
            sent++;
            if (phase_left > 0)
               phase_left--;
         end
         if (phase_left == 0) begin
            grow       = ~grow;
            phase_left = $urandom_range(60, 160);
            if (drains == 0 || $urandom_range(0, 2) == 0) begin
               wait_drained();
               drains++;
            end
         end
         if ($urandom_range(0, 3) != 0)
            hold_off($urandom_range(1, 12));
      end

      wait_drained();
      repeat (8) @(posedge clock);

      $display("covered %0d transactions, list peaked at %0d of %0d entries",
               tracker.ops_seen, tracker.peak_fill, CAPACITY);
      $display("status mix: %0d ok, %0d full, %0d not found, %0d out of range",
               tracker.status_seen[ST_OK], tracker.status_seen[ST_FULL],
               tracker.status_seen[ST_NOT_FOUND], tracker.status_seen[ST_RANGE]);
      if (tracker.errors == 0 && tracker.pending_results.size() == 0)
         $display("** ordered_list_engine: PASSED **");
      else
         $display("** ordered_list_engine: FAILED **");
      $finish;
   end

endmodule

### ordered_list_engine.f
src/olist_pkg.sv
src/olist_cell.sv
src/ordered_list_engine.sv
dv/ordered_list_engine_tb.sv
